### rtl/core/lmbp_pkg.sv
// Shared types, constants and the control program of the bifurcation point generator.
package lmbp_pkg;

   // Default population width and the configuration reset values.
   localparam int POPULATION_BITS_DEFAULT = 16;
   localparam logic [15:0] START_RATE_RESET  = 16'd16384;
   localparam logic [15:0] FINISH_RATE_RESET = 16'd65519;
   localparam logic [15:0] RATE_STEP_RESET   = 16'd76;
   localparam logic [15:0] INIT_POP_RESET    = 16'd6554;
   localparam logic [7:0]  WARMUP_RESET      = 8'd25;
   localparam logic [6:0]  PLOT_COUNT_RESET  = 7'd64;
   localparam logic [9:0]  ROWS_RESET        = 10'd480;

   // Fixed constants of the arithmetic.
   localparam logic [6:0]  MAX_POINTS   = 7'd64;
   localparam logic [6:0]  HUND_SCALE   = 7'd100;
   localparam logic [9:0]  COLUMN_MAX   = 10'd1023;
   localparam int          RATE_FRAC    = 14;
   localparam int          PC_BITS      = 4;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_START_RATE  = 3'd0,
      REG_FINISH_RATE = 3'd1,
      REG_RATE_STEP   = 3'd2,
      REG_INIT_POP    = 3'd3,
      REG_WARMUP      = 3'd4,
      REG_PLOT_COUNT  = 3'd5,
      REG_ROWS        = 3'd6
   } reg_index_type;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] start_rate;
      logic [15:0] finish_rate;
      logic [15:0] rate_step;
      logic [15:0] init_pop;
      logic [7:0]  warmup;
      logic [6:0]  plot_count;
      logic [9:0]  rows;
   } cfg_type;

   // Datapath operations selected by the control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOADX,
      OP_SQ,
      OP_RATE_WARM,
      OP_PINIT,
      OP_RATE_PLOT,
      OP_HUND,
      OP_EMIT,
      OP_END
   } op_type;

   // Sequencing conditions.
   typedef enum logic [2:0] {
      CND_NEXT,
      CND_JUMP,
      CND_WAIT_REQ,
      CND_PAST,
      CND_ZERO,
      CND_BUSY,
      CND_MORE
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [PC_BITS-1:0]   target;
   } uword_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic req_valid;
      logic past;
      logic cnt_zero;
      logic stop;
      logic out_busy;
   } status_type;

   // Control program: one word per step.
   function automatic uword_type ucode_rom(input logic [PC_BITS-1:0] pc);
      uword_type w;
      case (pc)
         4'd0:    w = '{OP_ACCEPT,    CND_WAIT_REQ, 4'd0};
         4'd1:    w = '{OP_LOADX,     CND_PAST,     4'd0};
         4'd2:    w = '{OP_NOP,       CND_ZERO,     4'd5};
         4'd3:    w = '{OP_SQ,        CND_NEXT,     4'd0};
         4'd4:    w = '{OP_RATE_WARM, CND_JUMP,     4'd2};
         4'd5:    w = '{OP_PINIT,     CND_NEXT,     4'd0};
         4'd6:    w = '{OP_SQ,        CND_NEXT,     4'd0};
         4'd7:    w = '{OP_RATE_PLOT, CND_NEXT,     4'd0};
         4'd8:    w = '{OP_HUND,      CND_NEXT,     4'd0};
         4'd9:    w = '{OP_EMIT,      CND_BUSY,     4'd9};
         4'd10:   w = '{OP_NOP,       CND_MORE,     4'd6};
         4'd11:   w = '{OP_END,       CND_JUMP,     4'd0};
         default: w = '{OP_NOP,       CND_JUMP,     4'd0};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/logistic_map_bifurcation_points_core.sv
// Top level of the logistic map bifurcation point generator.
//
//   Channel  Direction  Handshake          Contents
//   req      in         tvalid / tready    tdata[0] restart
//   rsp      out        tvalid / tready    tdata column, row, population; tlast last
//   csr      in         APB, pready high   seven registers at byte address 4*index
//
// A column runs the warmup iterations, then emits its points; every iteration is
// two passes through the one shared multiplier, each a step of the control program.
// A column past the finish rate emits nothing.
// Reset is synchronous; no clearing pass is needed.
// A stalled result word holds the program at its emit step; after the last point of the
// column enters the output register, the check and end steps precede the next accept step.
module logistic_map_bifurcation_points_core #(
   parameter int POPULATION_BITS = lmbp_pkg::POPULATION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input word, fields from bit 0: restart, zero fill.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Result word, fields from bit 0: column[9:0], row[19:10], population[35:20], zero fill.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lmbp_pkg::*;

   cfg_type     cfg;
   status_type  status;
   op_type      op;
   logic [9:0]  rsp_column;
   logic [9:0]  rsp_row;
   logic [15:0] rsp_population;

   lmbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lmbp_ucode u_ucode (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   lmbp_dpath #(
      .POPULATION_BITS (POPULATION_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .cfg            (cfg),
      .req_tvalid     (req_tvalid),
      .req_restart    (req_tdata[0]),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_population (rsp_population),
      .rsp_last       (rsp_tlast)
   );

   // The program takes a new word only at its accept step.
   assign req_tready = (op == OP_ACCEPT);
   assign rsp_tdata  = {4'd0, rsp_population, rsp_row, rsp_column};

endmodule

### rtl/core/lmbp_csr.sv
// Configuration register file behind the APB-style port.
module lmbp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output lmbp_pkg::cfg_type    cfg
);
   import lmbp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       write_en;

   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register update on a completed write; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_START_RATE:  cfg_in.start_rate  = csr_pwdata[15:0];
            REG_FINISH_RATE: cfg_in.finish_rate = csr_pwdata[15:0];
            REG_RATE_STEP:   cfg_in.rate_step   = csr_pwdata[15:0];
            REG_INIT_POP:    cfg_in.init_pop    = csr_pwdata[15:0];
            REG_WARMUP:      cfg_in.warmup      = csr_pwdata[7:0];
            REG_PLOT_COUNT:  cfg_in.plot_count  = csr_pwdata[6:0];
            REG_ROWS:        cfg_in.rows        = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_rate  <= START_RATE_RESET;
         cfg_ff.finish_rate <= FINISH_RATE_RESET;
         cfg_ff.rate_step   <= RATE_STEP_RESET;
         cfg_ff.init_pop    <= INIT_POP_RESET;
         cfg_ff.warmup      <= WARMUP_RESET;
         cfg_ff.plot_count  <= PLOT_COUNT_RESET;
         cfg_ff.rows        <= ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (index)
         REG_START_RATE:  csr_prdata = 32'(cfg_ff.start_rate);
         REG_FINISH_RATE: csr_prdata = 32'(cfg_ff.finish_rate);
         REG_RATE_STEP:   csr_prdata = 32'(cfg_ff.rate_step);
         REG_INIT_POP:    csr_prdata = 32'(cfg_ff.init_pop);
         REG_WARMUP:      csr_prdata = 32'(cfg_ff.warmup);
         REG_PLOT_COUNT:  csr_prdata = 32'(cfg_ff.plot_count);
         REG_ROWS:        csr_prdata = 32'(cfg_ff.rows);
         default:         csr_prdata = 32'd0;
      endcase
   end

endmodule

### rtl/core/lmbp_ucode.sv
// Microcode sequencer: step counter, control table and conditional jumps.
module lmbp_ucode (
   input  logic                   clock,
   input  logic                   reset,
   input  lmbp_pkg::status_type   status,
   output lmbp_pkg::op_type       op
);
   import lmbp_pkg::*;

   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;
   logic [PC_BITS-1:0] pc_next;
   uword_type          word;
   logic               take;

   assign word    = ucode_rom(pc_ff);
   assign op      = word.op;
   assign pc_next = PC_BITS'(pc_ff + 1'b1);

   // Jump condition of the current word.
   always_comb begin
      case (word.cond)
         CND_NEXT:     take = 1'b0;
         CND_JUMP:     take = 1'b1;
         CND_WAIT_REQ: take = !status.req_valid;
         CND_PAST:     take = status.past;
         CND_ZERO:     take = status.cnt_zero;
         CND_BUSY:     take = status.out_busy;
         CND_MORE:     take = !status.stop;
         default:      take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

### rtl/core/lmbp_dpath.sv
// Datapath: column state, one shared multiplier and the output register.
module lmbp_dpath #(
   parameter int POPULATION_BITS = lmbp_pkg::POPULATION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmbp_pkg::op_type      op,
   input  lmbp_pkg::cfg_type     cfg,
   input  logic                  req_tvalid,
   input  logic                  req_restart,
   input  logic                  rsp_tready,
   output lmbp_pkg::status_type  status,
   output logic                  rsp_tvalid,
   output logic [9:0]            rsp_column,
   output logic [9:0]            rsp_row,
   output logic [15:0]           rsp_population,
   output logic                  rsp_last
);
   import lmbp_pkg::*;

   localparam int P  = POPULATION_BITS;
   localparam int MA = P + 1;
   localparam int MB = (P > 17) ? P : 17;
   localparam int PW = MA + MB;

   // Q0.16 to Q0.P conversion.
   function automatic logic [P-1:0] from_q16(input logic [15:0] v);
      logic [31:0] wide;
      wide = {v, 16'd0} >> (32 - P);
      return wide[P-1:0];
   endfunction

   logic [16:0]  rate_ff,  rate_in;
   logic [P-1:0] pop_ff,   pop_in;
   logic [9:0]   col_ff,   col_in;
   logic [P-1:0] x_ff,     x_in;
   logic [P-1:0] d_ff,     d_in;
   logic [7:0]   cnt_ff,   cnt_in;
   logic         first_ff, first_in;
   logic         stop_ff,  stop_in;
   logic [6:0]   fph_ff,   fph_in;
   logic         valid_ff, valid_in;
   logic [9:0]   ocol_ff,  ocol_in;
   logic [9:0]   orow_ff,  orow_in;
   logic [15:0]  opop_ff,  opop_in;
   logic         olast_ff, olast_in;

   logic [MA-1:0] mul_a;
   logic [MB-1:0] mul_b;
   logic [PW-1:0] prod;
   logic [MA-1:0] one_minus_x;
   logic [P-1:0]  sq;
   logic [P+2:0]  rate_prod;
   logic [P-1:0]  x_sat;
   logic [6:0]    hund;
   logic [9:0]    row;
   logic [31:0]   pop_wide;
   logic [6:0]    limit;
   logic [17:0]   rate_sum;
   logic          out_free;

   assign one_minus_x = {1'b1, {P{1'b0}}} - {1'b0, x_ff};

   // Operand selection for the shared multiplier.
   always_comb begin
      case (op)
         OP_SQ: begin
            mul_a = MA'(x_ff);
            mul_b = MB'(x_ff);
         end
         OP_RATE_WARM, OP_RATE_PLOT: begin
            mul_a = MA'(d_ff);
            mul_b = MB'(rate_ff);
         end
         OP_HUND: begin
            mul_a = MA'(x_ff);
            mul_b = MB'(HUND_SCALE);
         end
         OP_EMIT: begin
            mul_a = one_minus_x;
            mul_b = MB'(cfg.rows);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod      = PW'(mul_a) * PW'(mul_b);
   assign sq        = prod[2*P-1:P];
   assign rate_prod = prod[P+2+RATE_FRAC:RATE_FRAC];
   assign x_sat     = (rate_prod[P+2:P] != 3'd0) ? {P{1'b1}} : rate_prod[P-1:0];
   assign hund      = prod[P+6:P];
   assign row       = prod[P+9:P];
   assign pop_wide  = 32'(x_ff) << (32 - P);
   assign rate_sum  = {1'b0, rate_ff} + 18'(cfg.rate_step);
   assign out_free  = !valid_ff || rsp_tready;

   // Points per column, clamped to one through the maximum.
   always_comb begin
      if (cfg.plot_count == 7'd0) begin
         limit = 7'd1;
      end else if (cfg.plot_count > MAX_POINTS) begin
         limit = MAX_POINTS;
      end else begin
         limit = cfg.plot_count;
      end
   end

   // Next state for the operation of this step.
   always_comb begin
      rate_in  = rate_ff;
      pop_in   = pop_ff;
      col_in   = col_ff;
      x_in     = x_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      stop_in  = stop_ff;
      fph_in   = fph_ff;
      valid_in = valid_ff && !rsp_tready;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      opop_in  = opop_ff;
      olast_in = olast_ff;
      case (op)
         OP_ACCEPT: begin
            if (req_tvalid && req_restart) begin
               rate_in = {1'b0, cfg.start_rate};
               pop_in  = from_q16(cfg.init_pop);
               col_in  = '0;
            end
         end
         OP_LOADX: begin
            x_in   = pop_ff;
            cnt_in = cfg.warmup;
         end
         OP_SQ: begin
            d_in = x_ff - sq;
         end
         OP_RATE_WARM, OP_RATE_PLOT: begin
            x_in   = x_sat;
            cnt_in = cnt_ff - 8'd1;
         end
         OP_PINIT: begin
            cnt_in   = 8'(limit);
            first_in = 1'b1;
         end
         OP_HUND: begin
            first_in = 1'b0;
            if (first_ff) begin
               fph_in  = hund;
               stop_in = (cnt_ff == 8'd0);
            end else begin
               stop_in = (cnt_ff == 8'd0) || (hund == fph_ff);
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               ocol_in  = col_ff;
               orow_in  = row;
               opop_in  = pop_wide[31:16];
               olast_in = stop_ff;
            end
         end
         OP_END: begin
            pop_in  = x_ff;
            rate_in = rate_sum[17] ? 17'h1FFFF : rate_sum[16:0];
            if (col_ff != COLUMN_MAX) begin
               col_in = col_ff + 10'd1;
            end
         end
         default: ;
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= {1'b0, START_RATE_RESET};
         pop_ff   <= from_q16(INIT_POP_RESET);
         col_ff   <= '0;
         valid_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         rate_ff  <= rate_in;
         pop_ff   <= pop_in;
         col_ff   <= col_in;
         valid_ff <= valid_in;
         first_ff <= first_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      stop_ff  <= stop_in;
      fph_ff   <= fph_in;
      ocol_ff  <= ocol_in;
      orow_ff  <= orow_in;
      opop_ff  <= opop_in;
      olast_ff <= olast_in;
   end

   assign status.req_valid = req_tvalid;
   assign status.past      = rate_ff > {1'b0, cfg.finish_rate};
   assign status.cnt_zero  = (cnt_ff == 8'd0);
   assign status.stop      = stop_ff;
   assign status.out_busy  = valid_ff && !rsp_tready;

   assign rsp_tvalid     = valid_ff;
   assign rsp_column     = ocol_ff;
   assign rsp_row        = orow_ff;
   assign rsp_population = opop_ff;
   assign rsp_last       = olast_ff;

endmodule

### rtl/core/lmbp_checker.sv
// Port-level checks of the bifurcation point generator, bound to the top level.
module lmbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // Reset leaves no result word pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // A new column is not taken while a point that is not the last one waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a column");

   // A point is emitted only from inside a column, never straight from the accept step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result word appeared right after the accept step");

endmodule

bind logistic_map_bifurcation_points_core lmbp_checker u_lmbp_checker (.*);

### dv/tb_logistic_map_bifurcation_points_core.sv
// Self-checking testbench for the logistic map bifurcation point generator.
module tb_logistic_map_bifurcation_points_core;
   import lmbp_pkg::*;

   // One plotted point as it leaves the block.
   typedef struct packed {
      logic [9:0]  column;
      logic [9:0]  row;
      logic [15:0] population;
      logic        last;
   } point_type;

   // How a column's expected points are obtained.
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_ONE
   } check_kind_type;

   // One row of the directed stimulus table.
   typedef struct packed {
      logic           reconfig;
      cfg_type        cfg;
      logic           restart;
      check_kind_type check;
      point_type      typed;
   } stim_row_type;

   localparam int          DIRECTED_ROWS  = 16;
   localparam int          SATURATE_WORDS = 12;
   localparam int          PHASES         = 6;
   localparam int          PHASE_WORDS    = 25;
   localparam int          SETTLE_CYCLES  = 40;
   localparam int          REG_COUNT      = 7;
   localparam logic [4:0]  SPARE_ADDR     = 5'd28;
   localparam logic [16:0] RATE_LIMIT     = 17'h1FFFF;
   localparam cfg_type     RESET_CFG      = '{START_RATE_RESET, FINISH_RATE_RESET,
                                              RATE_STEP_RESET, INIT_POP_RESET,
                                              WARMUP_RESET, PLOT_COUNT_RESET, ROWS_RESET};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Input word, fields from bit 0: restart, zero fill.
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Result word, fields from bit 0: column, row, population, zero fill.
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Handshake state sampled at the falling edge, read at the next rising edge.
   logic        req_take = 1'b0;
   logic        csr_done = 1'b0;
   logic [31:0] csr_rdata_seen = '0;

   // Bench copy of the block's configuration and column state.
   cfg_type     model_cfg = RESET_CFG;
   logic [16:0] cur_rate = {1'b0, START_RATE_RESET};
   logic [15:0] cur_pop = INIT_POP_RESET;
   logic [9:0]  cur_column = '0;
   logic [6:0]  first_hund = '0;

   point_type   expected_points[$];
   int          errors = 0;
   int          idle_chance = 0;
   int          stall_left = 0;

   logistic_map_bifurcation_points_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One logistic step: x' = r * (x - x*x), truncated at each product, saturated.
   function automatic logic [15:0] logistic_next(input logic [15:0] x, input logic [16:0] r);
      logic [31:0] square;
      logic [15:0] diff;
      logic [33:0] prod;
      square = x * x;
      diff   = x - square[31:16];
      prod   = (r * diff) >> RATE_FRAC;
      return (prod > 34'h0FFFF) ? 16'hFFFF : prod[15:0];
   endfunction

   // Predict one column, queue its points, then hand the word to the block.
   task automatic plot_column(input logic restart, input check_kind_type kind,
                              input point_type typed);
      logic [15:0] x;
      logic [6:0]  limit;
      logic [6:0]  k;
      logic [31:0] scaled;
      logic [26:0] height;
      logic [17:0] next_rate;
      logic        stop;
      point_type   pt;
      int          i;
      if (restart) begin
         cur_rate   = {1'b0, model_cfg.start_rate};
         cur_pop    = model_cfg.init_pop;
         cur_column = '0;
      end
      // A column past the finish rate plots nothing and leaves the state alone.
      if (cur_rate <= {1'b0, model_cfg.finish_rate}) begin
         x = cur_pop;
         for (i = 0; i < model_cfg.warmup; i++)
            x = logistic_next(x, cur_rate);
         limit = model_cfg.plot_count;
         if (limit == 0) limit = 7'd1;
         if (limit > MAX_POINTS) limit = MAX_POINTS;
         k    = '0;
         stop = 1'b0;
         // The column ends early once the hundredths repeat those of its first point.
         while (!stop) begin
            x      = logistic_next(x, cur_rate);
            scaled = 32'd100 * x;
            if (k == 0) first_hund = scaled[22:16];
            else stop = (scaled[22:16] == first_hund);
            if (k + 7'd1 == limit) stop = 1'b1;
            height = model_cfg.rows * (27'h10000 - x);
            pt     = '{cur_column, height[25:16], x, stop};
            if (kind == CHECK_MODEL) expected_points.push_back(pt);
            k++;
         end
         cur_pop   = x;
         next_rate = cur_rate + model_cfg.rate_step;
         cur_rate  = (next_rate > {1'b0, RATE_LIMIT}) ? RATE_LIMIT : next_rate[16:0];
         if (cur_column != COLUMN_MAX) cur_column++;
      end
      if (kind == CHECK_ONE) expected_points.push_back(typed);

      // Optional gap on the input side, then hold the word until it is taken.
      if (idle_chance > 0 && $urandom_range(0, 99) < idle_chance) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      @(posedge clock);
      while (!req_take) @(posedge clock);
   endtask

   // Stop sending and wait until every expected point has come out.
   task automatic drain_points();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer; the caller returns the bus to idle after the last one.
   task automatic csr_access(input logic wr, input logic [4:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_done) @(posedge clock);
      rdata = csr_rdata_seen;
   endtask

   // Write every register, poke the spare address, and read every register back.
   task automatic apply_config(input cfg_type c);
      logic [31:0] field_val  [REG_COUNT];
      logic [31:0] field_mask [REG_COUNT];
      logic [31:0] rd;
      int          i;
      field_val[REG_START_RATE]   = {16'd0, c.start_rate};
      field_val[REG_FINISH_RATE]  = {16'd0, c.finish_rate};
      field_val[REG_RATE_STEP]    = {16'd0, c.rate_step};
      field_val[REG_INIT_POP]     = {16'd0, c.init_pop};
      field_val[REG_WARMUP]       = {24'd0, c.warmup};
      field_val[REG_PLOT_COUNT]   = {25'd0, c.plot_count};
      field_val[REG_ROWS]         = {22'd0, c.rows};
      field_mask[REG_START_RATE]  = 32'h0000_FFFF;
      field_mask[REG_FINISH_RATE] = 32'h0000_FFFF;
      field_mask[REG_RATE_STEP]   = 32'h0000_FFFF;
      field_mask[REG_INIT_POP]    = 32'h0000_FFFF;
      field_mask[REG_WARMUP]      = 32'h0000_00FF;
      field_mask[REG_PLOT_COUNT]  = 32'h0000_007F;
      field_mask[REG_ROWS]        = 32'h0000_03FF;
      // Random bits above each field must be dropped by the register.
      for (i = 0; i < REG_COUNT; i++)
         csr_access(1'b1, 5'(4 * i), (32'($urandom) & ~field_mask[i]) | field_val[i], rd);
      // No register sits at the spare address, so this write changes nothing.
      csr_access(1'b1, SPARE_ADDR, 32'($urandom), rd);
      for (i = 0; i < REG_COUNT; i++) begin
         csr_access(1'b0, 5'(4 * i), 32'd0, rd);
         if (rd !== field_val[i]) begin
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, i, field_val[i], rd);
            errors++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      model_cfg = c;
   endtask

   // Output stalls come in bursts, started at random with the idle chance.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_chance > 0 && $urandom_range(0, 99) < idle_chance) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sample handshakes mid-cycle and check each result word against the oldest point.
   always @(negedge clock) begin
      point_type got;
      point_type want;
      req_take       = req_tvalid && req_tready;
      csr_done       = csr_psel && csr_penable && csr_pready;
      csr_rdata_seen = csr_prdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[35:20], rsp_tlast};
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected word column %0d row %0d population %0d last %0b",
                     $time, got.column, got.row, got.population, got.last);
            errors++;
         end else begin
            want = expected_points.pop_front();
            if (got !== want) begin
               $display({"%0t: expected column %0d row %0d population %0d last %0b,",
                         " actual column %0d row %0d population %0d last %0b"},
                        $time, want.column, want.row, want.population, want.last,
                        got.column, got.row, got.population, got.last);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows [DIRECTED_ROWS];
      cfg_type      c;
      int           k;
      int           p;
      int           lim;

      // Reset settings, first without and then with a restart.
      directed_rows[0]  = '{1'b0, RESET_CFG, 1'b0, CHECK_MODEL, '0};
      directed_rows[1]  = '{1'b0, RESET_CFG, 1'b1, CHECK_MODEL, '0};
      // Zero rate and zero population: one point on the bottom row, then the next column.
      directed_rows[2]  = '{1'b1, '{16'd0, 16'hFFFF, 16'd0, 16'd0, 8'd0, 7'd1, 10'd1023},
                            1'b1, CHECK_ONE, '{10'd0, 10'd1023, 16'd0, 1'b1}};
      directed_rows[3]  = '{1'b0, RESET_CFG, 1'b0, CHECK_ONE, '{10'd1, 10'd1023, 16'd0, 1'b1}};
      // Full rate on a full population collapses to 3; zero rows flatten every row.
      directed_rows[4]  = '{1'b1, '{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0, 7'd1, 10'd0},
                            1'b1, CHECK_ONE, '{10'd0, 10'd0, 16'd3, 1'b1}};
      directed_rows[5]  = '{1'b0, RESET_CFG, 1'b0, CHECK_MODEL, '0};
      // Start already past the finish rate: nothing comes out.
      directed_rows[6]  = '{1'b1, '{16'd100, 16'd50, 16'd0, 16'd1000, 8'd5, 7'd64, 10'd480},
                            1'b1, CHECK_NONE, '0};
      directed_rows[7]  = '{1'b0, RESET_CFG, 1'b0, CHECK_NONE, '0};
      // A plot count of zero still plots one point.
      directed_rows[8]  = '{1'b1, '{16'd0, 16'hFFFF, 16'd0, 16'd0, 8'd3, 7'd0, 10'd480},
                            1'b1, CHECK_ONE, '{10'd0, 10'd480, 16'd0, 1'b1}};
      // Plot count above 64 with the largest step; the next column is past the finish.
      directed_rows[9]  = '{1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd12345, 8'd10, 7'd127,
                                    10'd1023}, 1'b1, CHECK_MODEL, '0};
      directed_rows[10] = '{1'b0, RESET_CFG, 1'b0, CHECK_NONE, '0};
      // Period two after the longest warmup, so the column stops early.
      directed_rows[11] = '{1'b1, '{16'd52429, 16'hFFFF, 16'd0, 16'd6554, 8'd255, 7'd64,
                                    10'd480}, 1'b1, CHECK_MODEL, '0};
      directed_rows[12] = '{1'b0, RESET_CFG, 1'b0, CHECK_MODEL, '0};
      // Period four from half population, one row.
      directed_rows[13] = '{1'b1, '{16'd57672, 16'hFFFF, 16'd1, 16'd32768, 8'd40, 7'd64,
                                    10'd1}, 1'b1, CHECK_MODEL, '0};
      directed_rows[14] = '{1'b1, RESET_CFG, 1'b1, CHECK_MODEL, '0};
      directed_rows[15] = '{1'b0, RESET_CFG, 1'b0, CHECK_MODEL, '0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_chance = 10;
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         if (directed_rows[k].reconfig) begin
            drain_points();
            apply_config(directed_rows[k].cfg);
         end
         plot_column(directed_rows[k].restart, directed_rows[k].check, directed_rows[k].typed);
      end

      // Short one-point columns at a fixed rate, one after another.
      drain_points();
      c = '{16'($urandom), 16'hFFFF, 16'd0, 16'($urandom), 8'd0, 7'd1, 10'($urandom)};
      apply_config(c);
      for (k = 0; k < SATURATE_WORDS; k++)
         plot_column(k == 0, CHECK_MODEL, '0);

      // Random settings per phase, mostly in the upper end of the rate range.
      for (p = 0; p < PHASES; p++) begin
         drain_points();
         c.start_rate = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(45000, 65535));
         case ($urandom_range(0, 2))
            0: c.finish_rate = 16'hFFFF;
            1: begin
               lim = c.start_rate + $urandom_range(0, 3000);
               c.finish_rate = (lim > 65535) ? 16'hFFFF : 16'(lim);
            end
            default: c.finish_rate = 16'($urandom);
         endcase
         c.rate_step  = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 400));
         c.init_pop   = 16'($urandom);
         c.warmup     = (p == 2) ? 8'd255 : 8'($urandom_range(0, 40));
         c.plot_count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, 64));
         case ($urandom_range(0, 7))
            0:       c.rows = 10'd0;
            1:       c.rows = 10'd1023;
            default: c.rows = 10'($urandom);
         endcase
         apply_config(c);
         // Odd phases, the last among them, run without idling.
         idle_chance = (p % 2 == 1) ? 0 : $urandom_range(5, 30);
         for (k = 0; k < PHASE_WORDS; k++)
            plot_column(k == 0 || $urandom_range(0, 4) == 0, CHECK_MODEL, '0);
      end

      drain_points();
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
